[sv/bfa_pkg.sv]
// Package for the best-fit block allocator.
// Holds heap constants, tag layouts, status codes and sequencer states.
// No dependencies.
package bfa_pkg;

	// Heap geometry.
	localparam int HEAP_GRANULES = 2048;
	localparam int GRANULE_BYTES = 32;
	localparam int TAG_BYTES = 16;
	localparam int GRANULE_SHIFT = $clog2(GRANULE_BYTES);
	localparam int IDX_W = $clog2(HEAP_GRANULES);
	localparam int SIZE_W = IDX_W + 1;
	localparam int WALK_W = SIZE_W + 1;
	localparam int END_W = SIZE_W + 2;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_RANGE   = 2'd2,
		ST_DOUBLE  = 2'd3
	} status_t;

	// Operation codes.
	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	// Header tag: block size, block-start mark and allocated flag.
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              start;
		logic              alloc;
	} hd_tag_t;

	// Footer tag: block size and allocated flag.
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              alloc;
	} ft_tag_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		hd_tag_t          data;
	} hd_wr_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		ft_tag_t          data;
	} ft_wr_t;

	// Result of one item.
	typedef struct packed {
		logic [IDX_W-1:0] block_index;
		status_t          status;
	} res_t;

	// Sequencer status seen by the top level.
	typedef struct packed {
		logic idle;
		logic clearing;
		logic done;
	} ctrl_stat_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_A_END,
		S_A_W1,
		S_A_W2,
		S_F_RD,
		S_F_CHK,
		S_F_NCHK,
		S_F_PCHK,
		S_F_PUT,
		S_DONE
	} state_t;

endpackage

[sv/bfa_if.sv]
// Channel interfaces of the best-fit block allocator.
// Depends on bfa_pkg for field widths.
interface bfa_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] request_bytes;
	logic [11:0] free_index;

	modport source (output valid, operation, request_bytes, free_index, input ready);
	modport sink (input valid, operation, request_bytes, free_index, output ready);
endinterface

interface bfa_out_if;
	logic                      valid;
	logic                      ready;
	logic [bfa_pkg::IDX_W-1:0] block_index;
	logic [1:0]                status;

	modport source (output valid, block_index, status, input ready);
	modport sink (input valid, block_index, status, output ready);
endinterface

[sv/bfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[sv/bfa_ctrl.sv]
// Sequencer and shared datapath of the best-fit block allocator.
// Walks, splits and merges blocks through the header and footer tag RAMs.
// Depends on bfa_pkg.
module bfa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic [15:0]               request_bytes,
	input  logic [11:0]               free_index,
	output bfa_pkg::hd_wr_t           hd_wr,
	output logic [bfa_pkg::IDX_W-1:0] hd_raddr,
	input  bfa_pkg::hd_tag_t          hd_rdata,
	output bfa_pkg::ft_wr_t           ft_wr,
	output logic [bfa_pkg::IDX_W-1:0] ft_raddr,
	input  bfa_pkg::ft_tag_t          ft_rdata,
	output bfa_pkg::res_t             res,
	input  logic                      res_take,
	output bfa_pkg::ctrl_stat_t       stat
);
	localparam int IW = bfa_pkg::IDX_W;
	localparam int SW = bfa_pkg::SIZE_W;
	localparam int WW = bfa_pkg::WALK_W;
	localparam int EW = bfa_pkg::END_W;
	localparam int RB = 17;

	bfa_pkg::state_t  state_q, state_d;
	logic [IW-1:0]    clr_q;
	logic [SW-1:0]    need_q;
	logic [WW-1:0]    g_q;
	logic [IW-1:0]    best_q;
	logic [SW-1:0]    bsize_q;
	logic             found_q;
	logic [IW-1:0]    b_q;
	logic [WW-1:0]    sz_q;
	bfa_pkg::ft_tag_t pft_q;
	bfa_pkg::res_t    res_q;

	logic          accept;
	logic [RB-1:0] need_raw;
	logic [SW-1:0] need_calc;
	logic [WW-1:0] walk_next;
	logic          fits;
	logic [WW-1:0] nb;
	logic          prev_merge;
	logic [EW-1:0] put_end;
	logic [WW-1:0] a_end1;
	logic [WW-1:0] a_split;
	logic [WW-1:0] a_end2;

	assign accept = in_valid && in_ready;

	// Granules needed: payload plus tags, rounded up, at least one.
	assign need_raw = (RB'(request_bytes) + RB'(bfa_pkg::TAG_BYTES + bfa_pkg::GRANULE_BYTES - 1))
		>> bfa_pkg::GRANULE_SHIFT;
	assign need_calc = (need_raw == '0) ? SW'(1) : need_raw[SW-1:0];

	// Shared adders and compares of the walk, split and merge steps.
	assign walk_next = g_q + WW'(hd_rdata.size);
	assign fits = !hd_rdata.alloc && (hd_rdata.size >= need_q) &&
		(!found_q || (hd_rdata.size < bsize_q));
	assign nb = WW'(b_q) + sz_q;
	assign prev_merge = (b_q != '0) && !pft_q.alloc && (pft_q.size != '0) &&
		(pft_q.size <= SW'(b_q));
	assign put_end = EW'(b_q) + EW'(sz_q) - EW'(1);
	assign a_end1 = WW'(best_q) + WW'(need_q) - WW'(1);
	assign a_split = WW'(best_q) + WW'(need_q);
	assign a_end2 = WW'(best_q) + WW'(bsize_q) - WW'(1);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::S_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bfa_pkg::S_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
		end
	end

	// Next state, RAM ports and handshake.
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		hd_wr = '0;
		ft_wr = '0;
		hd_raddr = g_q[IW-1:0];
		ft_raddr = b_q - IW'(1);
		unique case (state_q)
			bfa_pkg::S_CLEAR: begin
				hd_wr.we = 1'b1;
				hd_wr.addr = clr_q;
				if (clr_q == '0) begin
					hd_wr.data.size = SW'(bfa_pkg::HEAP_GRANULES);
					hd_wr.data.start = 1'b1;
				end
				ft_wr.we = 1'b1;
				ft_wr.addr = clr_q;
				if (clr_q == IW'(bfa_pkg::HEAP_GRANULES - 1)) begin
					ft_wr.data.size = SW'(bfa_pkg::HEAP_GRANULES);
					state_d = bfa_pkg::S_IDLE;
				end
			end
			bfa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					if (operation == bfa_pkg::OP_ALLOC) begin
						state_d = bfa_pkg::S_A_RD;
					end else if (free_index >= 12'(bfa_pkg::HEAP_GRANULES)) begin
						state_d = bfa_pkg::S_DONE;
					end else begin
						state_d = bfa_pkg::S_F_RD;
					end
				end
			end
			bfa_pkg::S_A_RD: begin
				if (g_q >= WW'(bfa_pkg::HEAP_GRANULES)) begin
					state_d = bfa_pkg::S_A_END;
				end else begin
					state_d = bfa_pkg::S_A_CHK;
				end
			end
			bfa_pkg::S_A_CHK: begin
				if (hd_rdata.size == '0) begin
					state_d = bfa_pkg::S_A_END;
				end else begin
					state_d = bfa_pkg::S_A_RD;
				end
			end
			bfa_pkg::S_A_END: begin
				state_d = found_q ? bfa_pkg::S_A_W1 : bfa_pkg::S_DONE;
			end
			bfa_pkg::S_A_W1: begin
				hd_wr.we = 1'b1;
				hd_wr.addr = best_q;
				hd_wr.data = '{size: need_q, start: 1'b1, alloc: 1'b1};
				ft_wr.we = a_end1 < WW'(bfa_pkg::HEAP_GRANULES);
				ft_wr.addr = a_end1[IW-1:0];
				ft_wr.data = '{size: need_q, alloc: 1'b1};
				state_d = (bsize_q > need_q) ? bfa_pkg::S_A_W2 : bfa_pkg::S_DONE;
			end
			bfa_pkg::S_A_W2: begin
				hd_wr.we = 1'b1;
				hd_wr.addr = a_split[IW-1:0];
				hd_wr.data = '{size: bsize_q - need_q, start: 1'b1, alloc: 1'b0};
				ft_wr.we = a_end2 < WW'(bfa_pkg::HEAP_GRANULES);
				ft_wr.addr = a_end2[IW-1:0];
				ft_wr.data = '{size: bsize_q - need_q, alloc: 1'b0};
				state_d = bfa_pkg::S_DONE;
			end
			bfa_pkg::S_F_RD: begin
				hd_raddr = b_q;
				state_d = bfa_pkg::S_F_CHK;
			end
			bfa_pkg::S_F_CHK: begin
				hd_raddr = WW'(b_q) + WW'(hd_rdata.size) >= WW'(bfa_pkg::HEAP_GRANULES) ?
					b_q : IW'(WW'(b_q) + WW'(hd_rdata.size));
				if (!hd_rdata.start || !hd_rdata.alloc) begin
					state_d = bfa_pkg::S_DONE;
				end else if (WW'(b_q) + WW'(hd_rdata.size) < WW'(bfa_pkg::HEAP_GRANULES)) begin
					state_d = bfa_pkg::S_F_NCHK;
				end else begin
					state_d = bfa_pkg::S_F_PCHK;
				end
			end
			bfa_pkg::S_F_NCHK: begin
				if (hd_rdata.start && !hd_rdata.alloc) begin
					hd_wr.we = 1'b1;
					hd_wr.addr = nb[IW-1:0];
				end
				state_d = bfa_pkg::S_F_PCHK;
			end
			bfa_pkg::S_F_PCHK: begin
				if (prev_merge) begin
					hd_wr.we = 1'b1;
					hd_wr.addr = b_q;
				end
				state_d = bfa_pkg::S_F_PUT;
			end
			bfa_pkg::S_F_PUT: begin
				hd_wr.we = 1'b1;
				hd_wr.addr = b_q;
				hd_wr.data = '{size: sz_q[SW-1:0], start: 1'b1, alloc: 1'b0};
				ft_wr.we = put_end < EW'(bfa_pkg::HEAP_GRANULES);
				ft_wr.addr = put_end[IW-1:0];
				ft_wr.data = '{size: sz_q[SW-1:0], alloc: 1'b0};
				state_d = bfa_pkg::S_DONE;
			end
			bfa_pkg::S_DONE: begin
				if (res_take) begin
					state_d = bfa_pkg::S_IDLE;
				end
			end
			default: state_d = bfa_pkg::S_IDLE;
		endcase
	end

	// Datapath and result registers of the walk and merge steps.
	always_ff @(posedge clk) begin
		case (state_q)
			bfa_pkg::S_IDLE: begin
				need_q <= need_calc;
				g_q <= '0;
				found_q <= 1'b0;
				b_q <= free_index[IW-1:0];
				res_q <= '{block_index: '0, status: bfa_pkg::ST_RANGE};
			end
			bfa_pkg::S_A_CHK: begin
				if (hd_rdata.size != '0) begin
					g_q <= walk_next;
					if (fits) begin
						found_q <= 1'b1;
						best_q <= g_q[IW-1:0];
						bsize_q <= hd_rdata.size;
					end
				end
			end
			bfa_pkg::S_A_END: begin
				if (found_q) begin
					res_q <= '{block_index: best_q, status: bfa_pkg::ST_OK};
				end else begin
					res_q <= '{block_index: '0, status: bfa_pkg::ST_NOSPACE};
				end
			end
			bfa_pkg::S_F_CHK: begin
				pft_q <= ft_rdata;
				sz_q <= WW'(hd_rdata.size);
				if (!hd_rdata.start) begin
					res_q <= '{block_index: '0, status: bfa_pkg::ST_RANGE};
				end else begin
					res_q <= '{block_index: '0, status: bfa_pkg::ST_DOUBLE};
				end
			end
			bfa_pkg::S_F_NCHK: begin
				if (hd_rdata.start && !hd_rdata.alloc) begin
					sz_q <= sz_q + WW'(hd_rdata.size);
				end
			end
			bfa_pkg::S_F_PCHK: begin
				if (prev_merge) begin
					b_q <= b_q - pft_q.size[IW-1:0];
					sz_q <= sz_q + WW'(pft_q.size);
				end
			end
			bfa_pkg::S_F_PUT: begin
				res_q <= '{block_index: b_q, status: bfa_pkg::ST_OK};
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;
	assign stat.idle = (state_q == bfa_pkg::S_IDLE);
	assign stat.clearing = (state_q == bfa_pkg::S_CLEAR);
	assign stat.done = (state_q == bfa_pkg::S_DONE);
endmodule

[sv/best_fit_block_allocator_top.sv]
// Top level of the best-fit block allocator.
// Instantiates the tag RAMs, the sequencer and the result register.
// Depends on bfa_pkg, bfa_if, bfa_ram and bfa_ctrl.
//
//  channel  dir  fields                                   taken when
//  in_ch    in   operation, request_bytes, free_index     valid && ready
//  out_ch   out  block_index, status                      valid && ready
//
// An allocate walks the heap block by block, a read state and a check state per
// block, reading one header tag from the header RAM each visit.
// A free works through the same RAM port; an index beyond the
// heap is answered at once.
// After reset a clearing pass writes all 2048 tag entries before the first
// item is taken. One item is in work at a time; a result waits in
// the output register while the next item is taken and worked on.
module best_fit_block_allocator_top (
	input logic       clk,
	input logic       arst_n,
	bfa_in_if.sink    in_ch,
	bfa_out_if.source out_ch
);
	localparam int IW = bfa_pkg::IDX_W;

	bfa_pkg::hd_wr_t     hd_wr;
	bfa_pkg::ft_wr_t     ft_wr;
	logic [IW-1:0]       hd_raddr;
	logic [IW-1:0]       ft_raddr;
	logic [$bits(bfa_pkg::hd_tag_t)-1:0] hd_rbits;
	logic [$bits(bfa_pkg::ft_tag_t)-1:0] ft_rbits;
	bfa_pkg::res_t       res;
	bfa_pkg::ctrl_stat_t stat;
	logic                res_take;
	logic                out_valid_q;
	bfa_pkg::res_t       out_q;

	// Header tag RAM.
	bfa_ram #(
		.WIDTH($bits(bfa_pkg::hd_tag_t)),
		.DEPTH(bfa_pkg::HEAP_GRANULES)
	) u_hd_ram (
		.clk  (clk),
		.we   (hd_wr.we),
		.waddr(hd_wr.addr),
		.wdata(hd_wr.data),
		.raddr(hd_raddr),
		.rdata(hd_rbits)
	);

	// Footer tag RAM.
	bfa_ram #(
		.WIDTH($bits(bfa_pkg::ft_tag_t)),
		.DEPTH(bfa_pkg::HEAP_GRANULES)
	) u_ft_ram (
		.clk  (clk),
		.we   (ft_wr.we),
		.waddr(ft_wr.addr),
		.wdata(ft_wr.data),
		.raddr(ft_raddr),
		.rdata(ft_rbits)
	);

	bfa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.operation    (in_ch.operation),
		.request_bytes(in_ch.request_bytes),
		.free_index   (in_ch.free_index),
		.hd_wr        (hd_wr),
		.hd_raddr     (hd_raddr),
		.hd_rdata     (bfa_pkg::hd_tag_t'(hd_rbits)),
		.ft_wr        (ft_wr),
		.ft_raddr     (ft_raddr),
		.ft_rdata     (bfa_pkg::ft_tag_t'(ft_rbits)),
		.res          (res),
		.res_take     (res_take),
		.stat         (stat)
	);

	// Output register: a finished item moves in once the slot is free.
	assign res_take = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= stat.done;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && stat.done) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.block_index = out_q.block_index;
	assign out_ch.status = out_q.status;

	// Checks on sequencing and results.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("item taken while another is in work");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !in_ch.ready)
		else $error("input ready during the clearing pass");

	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status != bfa_pkg::ST_OK)) |-> (out_ch.block_index == '0))
		else $error("failed item carries a nonzero block index");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && res_take) |=> (out_ch.valid && !stat.done))
		else $error("finished item not moved to the output register");
endmodule
